FILE: hdl/qtfr_pkg.sv
// ----------------------------------------------------------------------------
// qtfr_pkg: shared constants for the quintic forward/return generator
// Register indexes, fixed field widths and the phase reset value.
// ----------------------------------------------------------------------------
package qtfr_pkg;

    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_PHASE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_1 = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_2  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TARGET_2 = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd1000;

endpackage

FILE: hdl/qtfr_divider.sv
// ----------------------------------------------------------------------------
// qtfr_divider: pipelined restoring divider
// Computes floor(num * 2^FRAC_BITS / den) one quotient bit per stage, with
// side-band data carried along. With num <= den the quotient never exceeds
// 2^FRAC_BITS.
// ----------------------------------------------------------------------------
module qtfr_divider #(
    parameter int unsigned FRAC_BITS = 24,
    parameter int unsigned SIDE_W    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [qtfr_pkg::PHASE_W-1:0]     num,
    input  logic [qtfr_pkg::PHASE_W-1:0]     den,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [FRAC_BITS:0]               quot,
    output logic [SIDE_W-1:0]                out_side
);
    // num <= den always, so quotient fits FRAC_BITS+1 bits.
    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned PW = qtfr_pkg::PHASE_W;

    logic [QW-1:0]     vld_reg;
    logic [PW-1:0]     rem_reg  [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [PW-1:0]     den_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    // One restoring step: subtract the divisor when it fits, shift in the
    // quotient bit. The remainder always stays below the divisor.
    function automatic logic [PW+QW-1:0] div_step(input logic [PW:0]   trial,
                                                  input logic [PW-1:0] dsor,
                                                  input logic [QW-1:0] q_in);
        logic [PW+1:0] diff;
        diff = {1'b0, trial} - {2'b00, dsor};
        if (diff[PW+1])
            return {trial[PW-1:0], q_in[QW-2:0], 1'b0};
        else
            return {diff[PW-1:0], q_in[QW-2:0], 1'b1};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[QW-2:0], in_valid};
    end

    // First stage compares num itself (quotient bit FRAC_BITS); every later
    // stage brings in a zero dividend bit.
    always_ff @(posedge clk)
    begin
        {rem_reg[0], q_reg[0]} <= div_step({1'b0, num}, den, '0);
        den_reg[0]  <= den;
        side_reg[0] <= in_side;
        for (int i = 1; i < QW; i++)
        begin
            {rem_reg[i], q_reg[i]} <= div_step({rem_reg[i-1], 1'b0}, den_reg[i-1],
                                               q_reg[i-1]);
            den_reg[i]  <= den_reg[i-1];
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];
endmodule

FILE: hdl/quintic_trajectory_forward_return_core.sv
// ----------------------------------------------------------------------------
// quintic_trajectory_forward_return_core
// Pipeline: FRAC_BITS+1 divider stages, then ten stages of polynomial and
// scaling multiplies between start and strobe.
// Throughput: one transaction per cycle; busy is never high.
// Reset: rst_n clears all valid bits and loads register reset values.
// ----------------------------------------------------------------------------
module quintic_trajectory_forward_return_core #(
    parameter int unsigned POS_WIDTH = 32,
    parameter int unsigned FRAC_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [qtfr_pkg::ELAPSED_W-1:0]       elapsed_ms,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qtfr_pkg::IDX_W-1:0]           cfg_index,
    input  logic [POS_WIDTH-1:0]                 cfg_data,
    output logic                                 strobe,
    output logic signed [POS_WIDTH-1:0]          desired_axis_one,
    output logic signed [POS_WIDTH-1:0]          desired_axis_two,
    output logic                                 in_return_phase,
    output logic                                 run_done
);
    localparam int unsigned PW = qtfr_pkg::PHASE_W;
    localparam int unsigned EW = qtfr_pkg::ELAPSED_W;
    localparam int unsigned QW = FRAC_BITS + 1;        // Q1.F width
    localparam int unsigned DW = POS_WIDTH + 1;        // difference width
    localparam int unsigned PSW = QW + 6;              // polynomial width, signed
    localparam int unsigned SIDE_W = 2;                // {ret, done}
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
    localparam logic [PSW-1:0] TEN_Q = PSW'(10) << FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [PW-1:0]        phase_reg;
    logic [POS_WIDTH-1:0] st1_reg, tg1_reg, st2_reg, tg2_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qtfr_pkg::PHASE_RESET;
            st1_reg   <= '0;
            tg1_reg   <= '0;
            st2_reg   <= '0;
            tg2_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qtfr_pkg::REG_PHASE:    phase_reg <= cfg_data[PW-1:0];
                qtfr_pkg::REG_START_1:  st1_reg   <= cfg_data;
                qtfr_pkg::REG_TARGET_1: tg1_reg   <= cfg_data;
                qtfr_pkg::REG_START_2:  st2_reg   <= cfg_data;
                qtfr_pkg::REG_TARGET_2: tg2_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: phase select ----------------
    // Zero phase acts as one; local time is clamped so the divider never
    // sees a numerator above the denominator.
    logic [PW-1:0]   phase_eff;
    logic [EW:0]     twice_phase;
    logic            ret_c, done_c;
    logic [EW-1:0]   local_c;
    logic [PW-1:0]   num_c;
    always_comb
    begin
        phase_eff   = (phase_reg == '0) ? PW'(1) : phase_reg;
        twice_phase = {1'b0, EW'(phase_eff)} << 1;
        ret_c       = elapsed_ms > EW'(phase_eff);
        done_c      = {1'b0, elapsed_ms} > twice_phase;
        local_c     = ret_c ? (elapsed_ms - EW'(phase_eff)) : elapsed_ms;
        num_c       = (local_c > EW'(phase_eff)) ? phase_eff : local_c[PW-1:0];
    end

    logic             dv_valid;
    logic [QW-1:0]    tau;
    logic [SIDE_W-1:0] dv_side;

    qtfr_divider #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(start), .num(num_c), .den(phase_eff),
        .in_side({ret_c, done_c}),
        .out_valid(dv_valid), .quot(tau), .out_side(dv_side)
    );

    // ---------------- polynomial pipeline ----------------
    // p1: t2 = tau^2 ; p2: t3 = t2*tau, p = 10 - 15 tau + 6 t2 ;
    // p3: s = t3*p clamped ; p4..: offsets per axis.
    logic [8:0] v_reg;
    logic [SIDE_W-1:0] sd_reg [9];

    logic [QW-1:0]      tau1_reg;
    logic [2*QW-1:0]    sq_reg;
    logic [QW-1:0]      tau2_reg, tau3_reg, t2_reg;
    logic [QW-1:0]      t3_reg;
    logic [QW+4:0]      p_reg;
    logic [2*QW+4:0]    sp_reg;
    logic [QW-1:0]      s_reg;

    logic [QW+4:0] p_calc;
    logic signed [PSW-1:0] p_signed;
    logic [2*QW-1:0] t3_full;
    logic [2*QW+4:0] sp_shift;
    always_comb
    begin
        t3_full  = t2_reg * tau3_reg;
        p_signed = $signed(TEN_Q + PSW'(t2_reg) * PSW'(6) - PSW'(tau3_reg) * PSW'(15));
        p_calc   = p_signed[PSW-1] ? '0 : p_signed[QW+4:0];
        sp_shift = sp_reg >> FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[7:0], dv_valid};
    end

    always_ff @(posedge clk)
    begin
        sd_reg[0] <= dv_side;
        for (int i = 1; i < 9; i++)
            sd_reg[i] <= sd_reg[i-1];
        tau1_reg <= (tau > ONE_Q) ? ONE_Q : tau;
        sq_reg   <= tau1_reg * tau1_reg;
        tau2_reg <= tau1_reg;
        // hold tau one more stage so it lines up with t2
        tau3_reg <= tau2_reg;
        t2_reg   <= QW'(sq_reg >> FRAC_BITS);
        t3_reg   <= QW'(t3_full >> FRAC_BITS);
        p_reg    <= p_calc;
        sp_reg   <= (2*QW+5)'(t3_reg) * p_reg;
        s_reg    <= (sp_shift > (2*QW+5)'(ONE_Q)) ? ONE_Q : QW'(sp_shift);
    end

    // ---------------- scaling: magnitude times s ----------------
    // Stage a: difference and sign; stage b: hi*s and lo*s; stage c: sum and
    // apply sign; stage d: add base. s_reg is valid at v_reg[5].
    logic [DW-1:0]        mag1_reg, mag2_reg;
    logic                 neg1_reg, neg2_reg;
    logic                 neg1_reg_d, neg2_reg_d;
    logic [POS_WIDTH-1:0] b1a_reg, b2a_reg, b1b_reg, b2b_reg, b1c_reg, b2c_reg;
    logic [QW-1:0]        sa_reg;
    logic [DW+QW-1:0]     hi1_reg, hi2_reg;
    logic [2*FRAC_BITS+QW-1:0] lo1_reg, lo2_reg;
    logic [DW-1:0]        off1_reg, off2_reg;

    logic signed [DW-1:0] d1_c, d2_c;
    logic [POS_WIDTH-1:0] fr1, to1, fr2, to2;
    logic [DW+QW-1:0]     sum1_c, sum2_c;
    always_comb
    begin
        fr1  = sd_reg[5][1] ? tg1_reg : st1_reg;
        to1  = sd_reg[5][1] ? st1_reg : tg1_reg;
        fr2  = sd_reg[5][1] ? tg2_reg : st2_reg;
        to2  = sd_reg[5][1] ? st2_reg : tg2_reg;
        d1_c = $signed({to1[POS_WIDTH-1], to1}) - $signed({fr1[POS_WIDTH-1], fr1});
        d2_c = $signed({to2[POS_WIDTH-1], to2}) - $signed({fr2[POS_WIDTH-1], fr2});
        sum1_c = hi1_reg + (DW+QW)'(lo1_reg >> FRAC_BITS);
        sum2_c = hi2_reg + (DW+QW)'(lo2_reg >> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        // a
        neg1_reg <= d1_c[DW-1];
        neg2_reg <= d2_c[DW-1];
        mag1_reg <= d1_c[DW-1] ? DW'(-d1_c) : DW'(d1_c);
        mag2_reg <= d2_c[DW-1] ? DW'(-d2_c) : DW'(d2_c);
        b1a_reg  <= sd_reg[5][0] ? st1_reg : fr1;
        b2a_reg  <= sd_reg[5][0] ? st2_reg : fr2;
        sa_reg   <= sd_reg[5][0] ? '0 : s_reg;
        // b
        hi1_reg  <= (DW+QW)'(mag1_reg >> FRAC_BITS) * sa_reg;
        hi2_reg  <= (DW+QW)'(mag2_reg >> FRAC_BITS) * sa_reg;
        lo1_reg  <= (2*FRAC_BITS+QW)'(mag1_reg[FRAC_BITS-1:0]) * sa_reg;
        lo2_reg  <= (2*FRAC_BITS+QW)'(mag2_reg[FRAC_BITS-1:0]) * sa_reg;
        b1b_reg  <= b1a_reg;
        b2b_reg  <= b2a_reg;
        // c
        off1_reg <= neg1_reg_d ? DW'(-sum1_c) : DW'(sum1_c);
        off2_reg <= neg2_reg_d ? DW'(-sum2_c) : DW'(sum2_c);
        b1c_reg  <= b1b_reg;
        b2c_reg  <= b2b_reg;
    end

    always_ff @(posedge clk)
    begin
        neg1_reg_d <= neg1_reg;
        neg2_reg_d <= neg2_reg;
    end

    // d: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe <= 1'b0;
        else
            strobe <= v_reg[8];
    end

    always_ff @(posedge clk)
    begin
        desired_axis_one <= b1c_reg + off1_reg[POS_WIDTH-1:0];
        desired_axis_two <= b2c_reg + off2_reg[POS_WIDTH-1:0];
        in_return_phase  <= sd_reg[8][1];
        run_done         <= sd_reg[8][0];
    end

    // ---------------- assertions ----------------
    a_done_implies_return: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (!run_done || in_return_phase))
        else $error("run_done without in_return_phase");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_s_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] |-> (s_reg <= ONE_Q))
        else $error("blend factor above one");
endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for quintic_trajectory_forward_return_core
// Drives elapsed-time ticks through the command port, programs phase and
// axis positions over the register channel, and checks every strobed set point
// against a hand-written row or an in-bench fixed-point model of the minimum-jerk curve.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W  = 32;
    localparam int FRAC   = 24;
    localparam int LAT    = FRAC + 11;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [POS_W-1:0] axis_one;
        logic [POS_W-1:0] axis_two;
        logic             ret;
        logic             done;
    } setpoint_t;

    typedef struct {
        logic [qtfr_pkg::ELAPSED_W-1:0] tick;
        bit                   typed;  // row carries a hand-written expectation
        setpoint_t            sp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [qtfr_pkg::ELAPSED_W-1:0] elapsed_ms = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [qtfr_pkg::IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0] cfg_data = '0;
    logic strobe;
    logic signed [POS_W-1:0] desired_axis_one;
    logic signed [POS_W-1:0] desired_axis_two;
    logic in_return_phase;
    logic run_done;

    // Shadow copy of the block's registers, updated on each write transaction
    logic [qtfr_pkg::PHASE_W-1:0] phase_q = qtfr_pkg::PHASE_RESET;
    longint start_one = 0, target_one = 0, start_two = 0, target_two = 0;

    setpoint_t pending_setpoints[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    int        send_idle_pct = 0;

    quintic_trajectory_forward_return_core dut (.*);

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Blend factor s in Q1.FRAC for local time within one phase
    function automatic longint unsigned blend_factor(input longint unsigned local_ms,
                                                     input longint unsigned phase);
        longint unsigned one_q, tau, t2, t3, s;
        longint p;
        one_q = 64'd1 << FRAC;
        tau = (local_ms << FRAC) / phase;
        if (tau > one_q) tau = one_q;
        t2 = (tau * tau) >> FRAC;
        t3 = (t2 * tau) >> FRAC;
        p = longint'(10 * one_q) - longint'(15 * tau) + longint'(6 * t2);
        if (p < 0) p = 0;
        s = (t3 * longint'(p)) >> FRAC;
        if (s > one_q) s = one_q;
        return s;
    endfunction

    // Move from one position toward another by s, truncating the offset toward zero
    function automatic longint blend_position(input longint from, input longint to,
                                              input longint unsigned s);
        longint d;
        longint unsigned mag, off;
        d = to - from;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        off = (mag >> FRAC) * s + (((mag & ((64'd1 << FRAC) - 1)) * s) >> FRAC);
        return (d < 0) ? from - longint'(off) : from + longint'(off);
    endfunction

    function automatic setpoint_t predict_setpoint(input logic [qtfr_pkg::ELAPSED_W-1:0] tick);
        setpoint_t sp;
        longint unsigned t, phase, s;
        longint a, b;
        t = tick;
        phase = (phase_q == 0) ? 1 : phase_q;  // zero phase acts as one millisecond
        sp.ret = 1'b0;
        sp.done = 1'b0;
        if (t <= phase)
        begin
            s = blend_factor(t, phase);
            a = blend_position(start_one, target_one, s);
            b = blend_position(start_two, target_two, s);
        end
        else if (t <= 2 * phase)
        begin
            s = blend_factor(t - phase, phase);
            sp.ret = 1'b1;
            a = blend_position(target_one, start_one, s);
            b = blend_position(target_two, start_two, s);
        end
        else
        begin
            sp.ret = 1'b1;
            sp.done = 1'b1;
            a = start_one;
            b = start_two;
        end
        sp.axis_one = a[POS_W-1:0];
        sp.axis_two = b[POS_W-1:0];
        return sp;
    endfunction

    // Compare each strobed set point with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_setpoints.size() == 0)
                report_mismatch("unexpected strobe", 1, 0);
            else
            begin
                setpoint_t want;
                want = pending_setpoints.pop_front();
                if (desired_axis_one !== want.axis_one)
                    report_mismatch("desired_axis_one", desired_axis_one,
                                    $signed(want.axis_one));
                if (desired_axis_two !== want.axis_two)
                    report_mismatch("desired_axis_two", desired_axis_two,
                                    $signed(want.axis_two));
                if (in_return_phase !== want.ret)
                    report_mismatch("in_return_phase", in_return_phase, want.ret);
                if (run_done !== want.done)
                    report_mismatch("run_done", run_done, want.done);
            end
        end
    end

    // Write one register, and mirror it in the shadow copy; then idle with cfg_valid low
    task automatic write_register(input logic [qtfr_pkg::IDX_W-1:0] idx,
                                  input logic [POS_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            qtfr_pkg::REG_PHASE:    phase_q = value[qtfr_pkg::PHASE_W-1:0];
            qtfr_pkg::REG_START_1:  start_one = longint'($signed(value));
            qtfr_pkg::REG_TARGET_1: target_one = longint'($signed(value));
            qtfr_pkg::REG_START_2:  start_two = longint'($signed(value));
            qtfr_pkg::REG_TARGET_2: target_two = longint'($signed(value));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_all(input logic [qtfr_pkg::PHASE_W-1:0] ph,
                               input logic [POS_W-1:0] s1,
                               input logic [POS_W-1:0] t1, input logic [POS_W-1:0] s2,
                               input logic [POS_W-1:0] t2);
        write_register(qtfr_pkg::REG_PHASE, POS_W'(ph));
        write_register(qtfr_pkg::REG_START_1, s1);
        write_register(qtfr_pkg::REG_TARGET_1, t1);
        write_register(qtfr_pkg::REG_START_2, s2);
        write_register(qtfr_pkg::REG_TARGET_2, t2);
    endtask

    // Drain outstanding set points, then let the pipeline settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        while (pending_setpoints.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LAT + 4) @(posedge clk);
    endtask

    // Issue one tick; hold start across back-to-back transactions
    task automatic send_tick(input logic [qtfr_pkg::ELAPSED_W-1:0] tick, input bit typed,
                             input setpoint_t typed_sp);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        elapsed_ms <= tick;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_setpoints.push_back(typed ? typed_sp : predict_setpoint(tick));
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [qtfr_pkg::ELAPSED_W-1:0] random_tick();
        longint unsigned ph;
        ph = (phase_q == 0) ? 1 : phase_q;
        case ($urandom_range(7, 0))
            0: return qtfr_pkg::ELAPSED_W'($urandom);
            1: return qtfr_pkg::ELAPSED_W'(ph);
            2: return qtfr_pkg::ELAPSED_W'(2 * ph + $urandom_range(1, 0));
            3: return qtfr_pkg::ELAPSED_W'(ph + $urandom_range(1, 0));
            default: return qtfr_pkg::ELAPSED_W'($urandom_range(int'(2 * ph + 2), 0));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        case ($urandom_range(5, 0))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return POS_W'($urandom_range(2000, 0)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    stim_row_t directed_rows[$];
    setpoint_t none_sp;

    initial
    begin
        setpoint_t sp;
        stim_row_t row;
        none_sp = '{default: '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset all positions are zero: any tick gives zero set points
        row = '{tick: 0, typed: 1, sp: '{0, 0, 0, 0}};          directed_rows.push_back(row);
        row = '{tick: 1000, typed: 1, sp: '{0, 0, 0, 0}};       directed_rows.push_back(row);
        row = '{tick: 1001, typed: 1, sp: '{0, 0, 1, 0}};       directed_rows.push_back(row);
        row = '{tick: 2000, typed: 1, sp: '{0, 0, 1, 0}};       directed_rows.push_back(row);
        row = '{tick: 2001, typed: 1, sp: '{0, 0, 1, 1}};       directed_rows.push_back(row);
        row = '{tick: 17'h1FFFF, typed: 1, sp: '{0, 0, 1, 1}};  directed_rows.push_back(row);
        foreach (directed_rows[i])
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].sp);
        end_burst();
        wait_idle();

        // Extremes of the positions over a short phase; boundaries typed in
        program_all(16'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        directed_rows.delete();
        row = '{tick: 0, typed: 1, sp: '{32'h8000_0000, 32'h7FFF_FFFF, 0, 0}};
        directed_rows.push_back(row);
        row = '{tick: 10, typed: 1, sp: '{32'h7FFF_FFFF, 32'h8000_0000, 0, 0}};
        directed_rows.push_back(row);
        row = '{tick: 20, typed: 1, sp: '{32'h8000_0000, 32'h7FFF_FFFF, 1, 0}};
        directed_rows.push_back(row);
        row = '{tick: 21, typed: 1, sp: '{32'h8000_0000, 32'h7FFF_FFFF, 1, 1}};
        directed_rows.push_back(row);
        for (int t = 1; t < 20; t += 3)
        begin
            row = '{tick: qtfr_pkg::ELAPSED_W'(t), typed: 0, sp: none_sp};
            directed_rows.push_back(row);
        end
        foreach (directed_rows[i])
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].sp);
        end_burst();
        wait_idle();

        // Zero phase acts as one millisecond; then the largest phase
        program_all(16'd0, 32'd5, 32'd1005, -32'sd7, 32'd0);
        for (int t = 0; t < 4; t++) send_tick(qtfr_pkg::ELAPSED_W'(t), 0, none_sp);
        send_tick(17'h1FFFF, 0, none_sp);
        end_burst();
        wait_idle();
        write_register(qtfr_pkg::REG_PHASE, 32'hFFFF);
        send_tick(17'h0FFFF, 0, none_sp);
        send_tick(17'h10000, 0, none_sp);
        send_tick(17'h1FFFE, 0, none_sp);
        send_tick(17'h1FFFF, 0, none_sp);
        end_burst();
        wait_idle();

        // Random phases: each block of ticks runs under a fresh register setting
        for (int blk = 0; blk < 21; blk++)
        begin
            case (blk % 3)
                0: send_idle_pct = 0;
                1: send_idle_pct = 71;
                default: send_idle_pct = 6;
            endcase
            case ($urandom_range(4, 0))
                0: sp.axis_one = 16'($urandom_range(5, 0));
                1: sp.axis_one = 16'hFFFF;
                2: sp.axis_one = 16'($urandom);
                default: sp.axis_one = 16'($urandom_range(3000, 1));
            endcase
            program_all(sp.axis_one[qtfr_pkg::PHASE_W-1:0], random_position(),
                        random_position(), random_position(), random_position());
            for (int n = 0; n < 50; n++)
            begin
                send_tick(random_tick(), 0, none_sp);
                if ($urandom_range(9, 0) == 0) end_burst();
            end
            end_burst();
            wait_idle();
        end

        if (error_count == 0 && pending_setpoints.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
